// File: src/mftds_pkg.sv
// Package with constants, types and helpers of the TDS converter.
package mftds_pkg;
  localparam int WindowLengthDefault = 16;
  localparam int CodeW = 16;
  localparam int TempW = 16;
  localparam int ReadW = 24;
  localparam int TdsW = 32;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;

  localparam logic signed [31:0] VoltScale = 32'sd2685356;
  localparam logic signed [63:0] PolyK3 = 64'sd8743813;
  localparam logic signed [63:0] PolyK2 = 64'sd16768041;
  localparam logic signed [63:0] PolyK1 = 64'sd56189911;
  localparam logic signed [15:0] CalSpan = 16'sd11264;

  localparam logic [CfgIdxW-1:0] RegTempCoef = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRefTemp = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStdRead = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDiRead = 2'd3;

  localparam logic [StatusW-1:0] StOk = 2'd0;
  localparam logic [StatusW-1:0] StCalEqual = 2'd1;
  localparam logic [StatusW-1:0] StFactorZero = 2'd2;
  localparam logic [StatusW-1:0] StSaturated = 2'd3;

  typedef struct packed {
    logic                    load;
    logic                    shift;
    logic signed [CodeW-1:0] code;
  } mftds_cell_ctrl_t;
endpackage

// File: src/median_filtered_tds_converter.sv
// Top level of the median-filtered TDS converter.
// Usage: input words on s_axis (adc_code, water_temperature) are accepted when
// the block is idle. The code is written into a ring window of WindowLength
// entries, copied into a chain of sorting cells and sorted by odd-even
// transposition. The median is scaled to volts and put through the cubic
// polynomial in three multiply steps, then two divisions on one serial
// divider give the compensated and calibrated result. The divisions take
// most of the time; a zero temperature factor or equal calibration readings
// skip both divisions and finish sooner, and a saturated first quotient
// skips the second.
// Only one item is in flight; s_axis_tready is low until the result word has
// left the output register. When m_axis_tready is low the result waits.
// Configuration writes on cfg are always taken and must occur while idle.
// Reset clears the window, the write slot and loads the register defaults.
module median_filtered_tds_converter
  import mftds_pkg::*;
#(
  parameter int WindowLength = WindowLengthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] adc_code, [31:16] water_temperature
  input  logic [31:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] tds_value, [47:32] median_code, [49:48] status, [55:50] zero
  output logic [55:0]         m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  localparam int SlotW = (WindowLength > 1) ? $clog2(WindowLength) : 1;
  localparam int CntW  = $clog2(WindowLength + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_SORT, S_MED, S_VOLT, S_P3, S_P2, S_P1, S_DIV1, S_WAIT1,
    S_CAL, S_DIV2, S_WAIT2, S_OUT
  } state_e;

  state_e state_q;
  logic signed [CodeW-1:0] win_q [WindowLength];
  logic [SlotW-1:0]        slot_q;
  logic signed [CodeW-1:0] cell_val [WindowLength];
  logic [CntW-1:0]         cnt_q;
  logic                    phase_q;
  mftds_cell_ctrl_t        cctrl;

  logic signed [15:0] tc_q, rt_q;
  logic signed [23:0] sr_q, dr_q;
  logic signed [TempW-1:0] temp_q;
  logic signed [CodeW-1:0] med_q;
  logic signed [21:0] v_q;
  logic signed [39:0] t_q;
  logic signed [63:0] prod_q, f_q, x_q, dd_q;
  logic [StatusW-1:0] status_q;
  logic signed [31:0] tds_q;
  logic               out_valid_q;

  logic               dstart;
  logic signed [63:0] dnum, dden, dquo;
  logic               ddone;

  logic signed [CodeW-1:0] in_code;
  logic signed [16:0]      mid_sum;
  logic signed [63:0]      lim;

  assign in_code = s_axis_tdata[15:0];
  assign cctrl.load  = (state_q == S_IDLE) && s_axis_tvalid;
  assign cctrl.shift = (state_q == S_SORT);
  assign cctrl.code  = in_code;

  for (genvar g = 0; g < WindowLength; g++) begin : g_cell
    logic signed [CodeW-1:0] init_v, left_v, right_v;
    assign init_v  = (slot_q == SlotW'(g)) ? cctrl.code : win_q[g];
    assign left_v  = (g > 0) ? cell_val[(g > 0) ? g - 1 : 0] : '0;
    assign right_v = (g < WindowLength - 1) ? cell_val[(g < WindowLength - 1) ? g + 1 : g]
                                            : '0;
    mftds_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cctrl),
      .odd_phase_i (phase_q),
      .cell_odd_i  (1'(g % 2)),
      .init_i      (init_v),
      .left_i      (left_v),
      .right_i     (right_v),
      .has_left_i  (g > 0),
      .has_right_i (g < WindowLength - 1),
      .value_o     (cell_val[g])
    );
  end

  always_comb begin
    mid_sum = '0;
    if ((WindowLength % 2) == 0) begin
      mid_sum = 17'(cell_val[WindowLength / 2 - 1]) + 17'(cell_val[WindowLength / 2]);
    end else begin
      mid_sum = {cell_val[WindowLength / 2], 1'b0};
    end
  end

  assign dstart = (state_q == S_DIV1) || (state_q == S_DIV2);
  assign dnum   = (state_q == S_DIV1) ? (64'(t_q) <<< 15) : prod_q;
  assign dden   = (state_q == S_DIV1) ? f_q : (dd_q <<< 4);

  mftds_divider #(.Width(64)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (dnum),
    .den_i   (dden),
    .done_o  (ddone),
    .quo_o   (dquo)
  );

  assign lim = 64'sd1 <<< 42;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      tc_q        <= 16'sd1311;
      rt_q        <= 16'sd6400;
      sr_q        <= 24'sd11304;
      dr_q        <= 24'sd40;
      for (int i = 0; i < WindowLength; i++) win_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegTempCoef: tc_q <= cfg_data_i[15:0];
          RegRefTemp:  rt_q <= cfg_data_i[15:0];
          RegStdRead:  sr_q <= cfg_data_i;
          RegDiRead:   dr_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            win_q[slot_q] <= in_code;
            slot_q  <= (slot_q == SlotW'(WindowLength - 1)) ? '0 : slot_q + 1'b1;
            temp_q  <= s_axis_tdata[31:16];
            cnt_q   <= '0;
            phase_q <= 1'b0;
            state_q <= S_SORT;
          end
        end
        S_SORT: begin
          phase_q <= ~phase_q;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == CntW'(WindowLength)) state_q <= S_MED;
        end
        S_MED: begin
          med_q   <= mid_sum[16:1];
          f_q     <= (64'sd1 <<< 24) + 64'(tc_q) * (64'(temp_q) - 64'(rt_q));
          dd_q    <= 64'(sr_q) - 64'(dr_q);
          state_q <= S_VOLT;
        end
        S_VOLT: begin
          v_q     <= 22'((64'(med_q) * 64'(VoltScale) + 64'sd32768) >>> 16);
          state_q <= S_P3;
        end
        S_P3: begin
          t_q     <= 40'(((64'(v_q) * PolyK3) >>> 16) - PolyK2);
          state_q <= S_P2;
        end
        S_P2: begin
          t_q     <= 40'(((64'(v_q) * 64'(t_q)) >>> 16) + PolyK1);
          state_q <= S_P1;
        end
        S_P1: begin
          t_q <= 40'((64'(v_q) * 64'(t_q)) >>> 16);
          if (f_q == 0) begin
            tds_q <= '0; status_q <= StFactorZero; state_q <= S_OUT;
          end else if (dd_q == 0) begin
            tds_q <= '0; status_q <= StCalEqual; state_q <= S_OUT;
          end else begin
            state_q <= S_DIV1;
          end
        end
        S_DIV1: state_q <= S_WAIT1;
        S_WAIT1: begin
          if (ddone) begin
            x_q     <= dquo - (64'(dr_q) <<< 4);
            state_q <= S_CAL;
          end
        end
        S_CAL: begin
          if (x_q >= lim || x_q <= -lim) begin
            tds_q    <= ((x_q > 0) == (dd_q > 0)) ? 32'h7FFFFFFF : 32'h80000000;
            status_q <= StSaturated;
            state_q  <= S_OUT;
          end else begin
            prod_q  <= x_q * 64'(CalSpan);
            state_q <= S_DIV2;
          end
        end
        S_DIV2: state_q <= S_WAIT2;
        S_WAIT2: begin
          if (ddone) begin
            if (dquo > 64'sh7FFFFFFF) begin
              tds_q <= 32'h7FFFFFFF; status_q <= StSaturated;
            end else if (dquo < -64'sh80000000) begin
              tds_q <= 32'h80000000; status_q <= StSaturated;
            end else begin
              tds_q <= dquo[31:0]; status_q <= StOk;
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
          end else if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, status_q, med_q, tds_q};
  assign cfg_ready_o   = 1'b1;
endmodule

// File: src/mftds_cell.sv
// One cell of the sorting chain: holds a code, compares and swaps with its neighbor.
module mftds_cell
  import mftds_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mftds_cell_ctrl_t        ctrl_i,
  input  logic                    odd_phase_i,
  input  logic                    cell_odd_i,
  input  logic signed [CodeW-1:0] init_i,
  input  logic signed [CodeW-1:0] left_i,
  input  logic signed [CodeW-1:0] right_i,
  input  logic                    has_left_i,
  input  logic                    has_right_i,
  output logic signed [CodeW-1:0] value_o
);
  logic signed [CodeW-1:0] value_d, value_q;
  logic                    pair_right, pair_left;

  always_comb begin
    pair_right = (cell_odd_i == odd_phase_i) && has_right_i;
    pair_left  = (cell_odd_i != odd_phase_i) && has_left_i;
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = init_i;
    end else if (ctrl_i.shift) begin
      if (pair_right && right_i < value_q) begin
        value_d = right_i;
      end else if (pair_left && left_i > value_q) begin
        value_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;
endmodule

// File: src/mftds_divider.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module mftds_divider
  import mftds_pkg::*;
#(
  parameter int Width = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [Width-1:0] num_i,
  input  logic signed [Width-1:0] den_i,
  output logic                    done_o,
  output logic signed [Width-1:0] quo_o
);
  localparam int CntW = $clog2(Width + 1);
  logic [Width-1:0] rem_q, quo_q, den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, neg_q, done_q;
  logic [Width:0]   trial;
  logic [Width-1:0] rem_sh;

  always_comb begin
    rem_sh = {rem_q[Width-2:0], quo_q[Width-1]};
    trial  = {1'b0, rem_sh} - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
        neg_q  <= num_i[Width-1] ^ den_i[Width-1];
        rem_q  <= '0;
        quo_q  <= num_i[Width-1] ? -num_i : num_i;
        den_q  <= den_i[Width-1] ? -den_i : den_i;
      end else if (busy_q) begin
        if (!trial[Width]) begin
          rem_q <= trial[Width-1:0];
          quo_q <= {quo_q[Width-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[Width-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
